[src/ptad_pkg.sv]
// Shared types and constants of the armored text decompressor.
// Used by the output queue and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ptad_pkg;

  // One input beat
  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
    logic       final_char;
  } ptad_in_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stream_end;
    logic       last;
  } ptad_out_t;

  // Request from the decode controller to the output queue
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [7:0] byte_val;
    logic       has_byte;
    logic       stream_end;
  } ptad_oq_req_t;

  // Output queue status back to the controller
  typedef struct packed {
    logic ready;
    logic pend_v;
  } ptad_oq_sts_t;

  // Action codes
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Escape phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_OPEN = 2'd1;
  localparam logic [1:0] ESC_OCT2 = 2'd2;
  localparam logic [1:0] ESC_OCT3 = 2'd3;

  // Character codes
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_LO     = 8'd32;
  localparam logic [7:0] CHAR_HI     = 8'd126;
  localparam logic [7:0] CHAR_QUOTE  = 8'd34;
  localparam logic [7:0] CHAR_BSLASH = 8'd92;
  localparam logic [7:0] CHAR_N      = 8'd110;
  localparam logic [7:0] CHAR_PLUS   = 8'd43;
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_NINE   = 8'd57;

  // Value mapping
  localparam logic [15:0] VAL_ZERO  = 16'd48;
  localparam logic [15:0] VAL_NINE  = 16'd57;
  localparam logic [15:0] VAL_CR    = 16'd13;
  localparam logic [15:0] VAL_LF    = 16'd10;
  localparam logic [15:0] OCT2_BIAS = 16'd384;
  localparam logic [5:0]  SYM_BIAS  = 6'd58;
  localparam logic [2:0]  LAST_BIT  = 3'd5;
  localparam logic [3:0]  LIT_BITS  = 4'd8;

endpackage : ptad_pkg

`default_nettype wire

[src/ptad_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ptad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : ptad_ram

`default_nettype wire

[src/ptad_outq.sv]
// Output queue: one pending result plus the output register.
// The pending slot lets the last flag be set once the item is done. Uses ptad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptad_outq (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ptad_pkg::ptad_oq_req_t  req,
  output ptad_pkg::ptad_oq_sts_t       sts,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output ptad_pkg::ptad_out_t          out_data
);

  import ptad_pkg::*;

  logic      pend_v_r, pend_v_nxt;
  ptad_out_t pend_r, pend_nxt;
  logic      out_v_r, out_v_nxt;
  ptad_out_t out_r, out_nxt;
  logic      slot_free;
  logic      ready;
  logic      load;

  assign slot_free = !out_v_r || !out_stall;
  assign ready     = !pend_v_r || slot_free;
  assign load      = ready && pend_v_r && (req.push || req.flush);

  // Move pending beat out, take the new one
  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_nxt    = out_r;
    if (load) begin
      out_nxt      = pend_r;
      out_nxt.last = req.flush;
    end
    if (req.push && ready) begin
      pend_v_nxt          = 1'b1;
      pend_nxt.out_byte   = req.byte_val;
      pend_nxt.has_byte   = req.has_byte;
      pend_nxt.stream_end = req.stream_end;
      pend_nxt.last       = 1'b0;
    end else if (req.flush && ready) begin
      pend_v_nxt = 1'b0;
    end
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_stall) begin
      out_v_nxt = out_v_r;
    end else begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign sts.ready  = ready;
  assign sts.pend_v = pend_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_r;

endmodule : ptad_outq

`default_nettype wire

[src/predictive_text_armored_decompressor.sv]
// Top level of the armored text decompressor: decode controller, prediction table
// and output queue. Uses ptad_pkg, ptad_ram and ptad_outq.
//
// Usage: feed one source character per input beat on in_valid/in_stall/in_data.
// action = start clears all state and the prediction table and gives no result.
// Each character yields zero to seven result beats on out_valid/out_stall/out_data;
// the last beat an item causes carries last = 1. An item that causes nothing
// returns no beat.
// A character that carries six bits goes through the accept, a decode step, one
// bit step per bit, a final-mark step and a flush step before the next accept;
// escape, limit and dropped characters skip the bit steps, a closing quote or a
// zero limit skips the final-mark step as well, and a limit that runs out inside
// a character ends it early. The bit loop is set by the table read: the RAM is
// read every cycle at the next context, with a forward of the byte written in the
// previous cycle, so the loop takes one bit per cycle while no result waits for room.
// Reset and start run a clearing pass over all 2**CONTEXT_BITS table entries (4096
// at the default); in_stall stays high during it.
// A stalled receiver holds the output register; decoding continues until a second
// result needs room, then waits. in_stall is low only between items.
`timescale 1ns / 1ps
`default_nettype none

module predictive_text_armored_decompressor #(
  parameter int CONTEXT_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ptad_pkg::ptad_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ptad_pkg::ptad_out_t     out_data
);

  import ptad_pkg::*;

  localparam int DEPTH = 1 << CONTEXT_BITS;
  localparam int CW    = CONTEXT_BITS + 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_BITS   = 3'd2;
  localparam logic [2:0] S_LEND   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [CONTEXT_BITS-1:0] ctx_r, ctx_nxt;
  logic [7:0]              acc_r, acc_nxt;
  logic [3:0]              lit_left_r, lit_left_nxt;
  logic                    limit_r, limit_nxt;
  logic [3:0]              bits_left_r, bits_left_nxt;
  logic [1:0]              esc_phase_r, esc_phase_nxt;
  logic [15:0]             esc_val_r, esc_val_nxt;
  logic                    finished_r, finished_nxt;
  logic [CONTEXT_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [7:0]              chr_r, chr_nxt;
  logic                    final_r, final_nxt;
  logic [5:0]              sym_r, sym_nxt;
  logic [2:0]              bit_idx_r, bit_idx_nxt;
  logic                    fwd_hit_r;
  logic [7:0]              fwd_data_r;

  logic                    adv;
  logic                    we_c;
  logic                    ram_we;
  logic [CONTEXT_BITS-1:0] ram_waddr;
  logic [7:0]              ram_wdata;
  logic [CONTEXT_BITS-1:0] ram_raddr;
  logic [7:0]              ram_rdata;
  logic [7:0]              pred;
  logic [CW-1:0]           ctx_wide;

  // Decode temporaries
  logic                    take;
  logic                    run_v;
  logic [15:0]             run_val;
  logic [15:0]             oct_sum;
  logic                    end_now;
  logic                    bit_v;
  logic                    emit;
  logic [7:0]              ebyte;
  logic [7:0]              acc_new;
  logic [3:0]              bl_dec;
  logic                    lim_end;

  ptad_oq_req_t oq_req;
  ptad_oq_sts_t oq_sts;

  assign in_stall = (state_r != S_IDLE);
  assign pred     = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign ctx_wide = {ctx_r, 4'd0} + CW'(ebyte);

  // Hold the controller and item state while a result waits for room
  assign adv = !(oq_req.push && !oq_sts.ready);

  // Controller next state
  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    acc_nxt       = acc_r;
    lit_left_nxt  = lit_left_r;
    limit_nxt     = limit_r;
    bits_left_nxt = bits_left_r;
    esc_phase_nxt = esc_phase_r;
    esc_val_nxt   = esc_val_r;
    finished_nxt  = finished_r;
    clr_cnt_nxt   = clr_cnt_r;
    chr_nxt       = chr_r;
    final_nxt     = final_r;
    sym_nxt       = sym_r;
    bit_idx_nxt   = bit_idx_r;
    oq_req        = '0;
    we_c          = 1'b0;
    ram_waddr     = ctx_r;
    ram_wdata     = 8'd0;
    take          = (chr_r inside {[CHAR_LO:CHAR_HI]}) && (chr_r != CHAR_LF);
    run_v         = 1'b0;
    run_val       = {8'd0, chr_r};
    oct_sum       = esc_val_r + 16'(chr_r) - VAL_ZERO;
    end_now       = 1'b0;
    bit_v         = sym_r[bit_idx_r];
    emit          = 1'b0;
    ebyte         = pred;
    acc_new       = acc_r | (8'(bit_v) << 3'(LIT_BITS - lit_left_r));
    bl_dec        = bits_left_r - 4'd1;
    lim_end       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_START) begin
            state_nxt     = S_CLEAR;
            clr_cnt_nxt   = '0;
            ctx_nxt       = '0;
            acc_nxt       = 8'd0;
            lit_left_nxt  = 4'd0;
            limit_nxt     = 1'b0;
            bits_left_nxt = 4'd0;
            esc_phase_nxt = ESC_NONE;
            esc_val_nxt   = 16'd0;
            finished_nxt  = 1'b0;
          end else if (!finished_r) begin
            chr_nxt   = in_data.char_code;
            final_nxt = in_data.final_char;
            state_nxt = S_DECODE;
          end
        end
      end

      S_DECODE: begin
        state_nxt = S_FIN;
        // Resolve escapes
        if (take) begin
          case (esc_phase_r)
            ESC_NONE: begin
              if (chr_r == CHAR_QUOTE) begin
                end_now = 1'b1;
              end else if (chr_r == CHAR_BSLASH) begin
                esc_phase_nxt = ESC_OPEN;
              end else begin
                run_v = 1'b1;
              end
            end
            ESC_OPEN: begin
              esc_phase_nxt = ESC_NONE;
              if (chr_r inside {[CHAR_ZERO:CHAR_NINE]}) begin
                esc_val_nxt   = (16'(chr_r) - VAL_ZERO) << 6;
                esc_phase_nxt = ESC_OCT2;
              end else if (chr_r == CHAR_N) begin
                run_v   = 1'b1;
                run_val = VAL_LF;
              end else if (chr_r != CHAR_PLUS) begin
                run_v = 1'b1;
              end
            end
            ESC_OCT2: begin
              esc_val_nxt   = esc_val_r + (16'(chr_r) << 3) - OCT2_BIAS;
              esc_phase_nxt = ESC_OCT3;
            end
            default: begin
              esc_val_nxt   = oct_sum;
              esc_phase_nxt = ESC_NONE;
              run_v         = 1'b1;
              run_val       = (oct_sum == VAL_CR) ? VAL_LF : oct_sum;
            end
          endcase
        end
        // Digit sets the bit limit, anything else gives six bits
        if (run_v) begin
          if (run_val inside {[VAL_ZERO:VAL_NINE]}) begin
            limit_nxt     = 1'b1;
            bits_left_nxt = 4'(run_val - VAL_ZERO);
            if (4'(run_val - VAL_ZERO) == 4'd0) begin
              end_now = 1'b1;
            end
          end else begin
            sym_nxt     = run_val[5:0] - SYM_BIAS;
            bit_idx_nxt = 3'd0;
            state_nxt   = S_BITS;
          end
        end
        if (end_now) begin
          oq_req.push       = 1'b1;
          oq_req.stream_end = 1'b1;
          finished_nxt      = 1'b1;
          state_nxt         = S_FLUSH;
        end
      end

      S_BITS: begin
        // Literal bit, literal start or predicted byte
        if (lit_left_r != 4'd0) begin
          acc_nxt      = acc_new;
          lit_left_nxt = lit_left_r - 4'd1;
          if (lit_left_r == 4'd1) begin
            emit  = 1'b1;
            ebyte = acc_new;
          end
        end else if (bit_v) begin
          acc_nxt      = 8'd0;
          lit_left_nxt = LIT_BITS;
        end else begin
          emit = 1'b1;
        end
        // Count down the bit limit
        if (limit_r) begin
          bits_left_nxt = bl_dec;
          lim_end       = (bl_dec == 4'd0);
        end
        if (emit) begin
          oq_req.push     = 1'b1;
          oq_req.byte_val = ebyte;
          oq_req.has_byte = 1'b1;
          we_c            = 1'b1;
          ram_wdata       = ebyte;
          ctx_nxt         = ctx_wide[CONTEXT_BITS-1:0];
          if (lim_end) begin
            state_nxt = S_LEND;
          end
        end else if (lim_end) begin
          oq_req.push       = 1'b1;
          oq_req.stream_end = 1'b1;
          finished_nxt      = 1'b1;
          state_nxt         = S_FLUSH;
        end
        if (!lim_end) begin
          if (bit_idx_r == LAST_BIT) begin
            state_nxt = S_FIN;
          end else begin
            bit_idx_nxt = bit_idx_r + 3'd1;
          end
        end
      end

      S_LEND: begin
        oq_req.push       = 1'b1;
        oq_req.stream_end = 1'b1;
        finished_nxt      = 1'b1;
        state_nxt         = S_FLUSH;
      end

      S_FIN: begin
        // End at the last character of the buffer
        if (!finished_r && final_r) begin
          oq_req.push       = 1'b1;
          oq_req.stream_end = 1'b1;
          finished_nxt      = 1'b1;
        end
        state_nxt = S_FLUSH;
      end

      S_FLUSH: begin
        oq_req.flush = 1'b1;
        if (oq_sts.ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_CLEAR: begin
        we_c        = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 8'd0;
        clr_cnt_nxt = clr_cnt_r + CONTEXT_BITS'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Table access: read at the context of the next cycle
  assign ram_we    = we_c && adv;
  assign ram_raddr = adv ? ctx_nxt : ctx_r;

  ptad_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptad_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (oq_req),
    .sts       (oq_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ctx_r       <= '0;
      acc_r       <= 8'd0;
      lit_left_r  <= 4'd0;
      limit_r     <= 1'b0;
      bits_left_r <= 4'd0;
      esc_phase_r <= ESC_NONE;
      esc_val_r   <= 16'd0;
      finished_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      fwd_hit_r <= ram_we && (ram_waddr == ram_raddr);
      if (adv) begin
        state_r     <= state_nxt;
        clr_cnt_r   <= clr_cnt_nxt;
        ctx_r       <= ctx_nxt;
        acc_r       <= acc_nxt;
        lit_left_r  <= lit_left_nxt;
        limit_r     <= limit_nxt;
        bits_left_r <= bits_left_nxt;
        esc_phase_r <= esc_phase_nxt;
        esc_val_r   <= esc_val_nxt;
        finished_r  <= finished_nxt;
      end
    end
  end

  // Item payload and write forward
  always_ff @(posedge clk) begin
    fwd_data_r <= ram_wdata;
    if (adv) begin
      chr_r     <= chr_nxt;
      final_r   <= final_nxt;
      sym_r     <= sym_nxt;
      bit_idx_r <= bit_idx_nxt;
    end
  end

  // Checks
  a_pend_empty_between_items: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_CLEAR) |-> !oq_sts.pend_v)
    else $error("pending result left over between items");

  a_bits_only_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BITS) |-> (!finished_r && lit_left_r <= LIT_BITS))
    else $error("bit step after stream end or bad literal count");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_cnt_r == '1) |=> (state_r == S_IDLE))
    else $error("clearing pass did not end at the last entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");

endmodule : predictive_text_armored_decompressor

`default_nettype wire

[test/predictive_text_armored_decompressor_test.sv]
// Self-checking testbench for the armored text decompressor.
// It predicts each result beat from the source characters and checks the out channel
// against the prediction. Depends on ptad_pkg and predictive_text_armored_decompressor.
`timescale 1ns / 1ps

module predictive_text_armored_decompressor_test;
  import ptad_pkg::*;

  localparam int CTX_BITS      = 12;
  localparam int CTX_DEPTH     = 1 << CTX_BITS;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int RANDOM_ITEMS  = 250;
  localparam int MAX_STREAMS   = 60;

  // Prediction of the decoded byte stream, plus the beats still due
  class decode_scoreboard;
    bit [7:0]          pred_mem [CTX_DEPTH];
    bit [CTX_BITS-1:0] ctx;
    bit [7:0]          lit_acc;
    bit [3:0]          lit_left;
    bit                limit_on;
    bit [3:0]          bits_left;
    bit [1:0]          esc_phase;
    bit [15:0]         esc_val;
    bit                finished;
    ptad_out_t         due_results[$];
    int                errors;

    function void clear();
      foreach (pred_mem[i]) pred_mem[i] = 8'h00;
      ctx       = '0;
      lit_acc   = '0;
      lit_left  = '0;
      limit_on  = 1'b0;
      bits_left = '0;
      esc_phase = ESC_NONE;
      esc_val   = '0;
      finished  = 1'b0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void push_result(bit [7:0] b, bit has, bit fin);
      ptad_out_t r;
      r.out_byte   = b;
      r.has_byte   = has;
      r.stream_end = fin;
      r.last       = 1'b0;
      due_results.push_back(r);
    endfunction

    function void end_stream();
      finished = 1'b1;
      push_result(8'h00, 1'b0, 1'b1);
    endfunction

    // Learn the byte at the current context, then shift it into the context
    function void emit(bit [7:0] b);
      pred_mem[ctx] = b;
      ctx = {ctx[CTX_BITS-5:0], 4'h0} + CTX_BITS'(b);
      push_result(b, 1'b1, 1'b0);
    endfunction

    // A digit value sets the bit limit; anything else gives six code bits
    function void decode_value(bit [15:0] v);
      bit [5:0] sym;
      if (v >= VAL_ZERO && v <= VAL_NINE) begin
        limit_on  = 1'b1;
        bits_left = 4'(v - VAL_ZERO);
        if (bits_left == 0) end_stream();
        return;
      end
      sym = v[5:0] - SYM_BIAS;
      for (int i = 0; i <= LAST_BIT; i++) begin
        if (lit_left != 0) begin
          lit_acc[LIT_BITS - lit_left] = sym[i];
          lit_left--;
          if (lit_left == 0) emit(lit_acc);
        end else if (sym[i]) begin
          lit_acc  = 8'h00;
          lit_left = LIT_BITS;
        end else begin
          emit(pred_mem[ctx]);
        end
        if (limit_on) begin
          bits_left--;
          if (bits_left == 0) begin
            end_stream();
            return;
          end
        end
      end
    endfunction

    // Resolve escapes, one printable character at a time
    function void take_char(bit [7:0] c);
      case (esc_phase)
        ESC_NONE: begin
          if (c == CHAR_QUOTE) end_stream();
          else if (c == CHAR_BSLASH) esc_phase = ESC_OPEN;
          else decode_value({8'h00, c});
        end
        ESC_OPEN: begin
          esc_phase = ESC_NONE;
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            esc_val   = {8'h00, c - CHAR_ZERO} << 6;
            esc_phase = ESC_OCT2;
          end else if (c == CHAR_N) begin
            decode_value(VAL_LF);
          end else if (c != CHAR_PLUS) begin
            decode_value({8'h00, c});
          end
        end
        ESC_OCT2: begin
          esc_val   = esc_val + {5'd0, c, 3'd0} - OCT2_BIAS;
          esc_phase = ESC_OCT3;
        end
        default: begin
          esc_val   = esc_val + {8'h00, c} - VAL_ZERO;
          esc_phase = ESC_NONE;
          decode_value(esc_val == VAL_CR ? VAL_LF : esc_val);
        end
      endcase
    endfunction

    // Queue the beats of one accepted input; true for a character in an open stream
    function bit note_char_beat(ptad_in_t d);
      int        first;
      bit        live;
      ptad_out_t r;
      first = due_results.size();
      if (d.action == ACT_START) begin
        clear();
        return 1'b0;
      end
      live = !finished;
      if (!finished) begin
        if (d.char_code != CHAR_LF && d.char_code >= CHAR_LO && d.char_code <= CHAR_HI)
          take_char(d.char_code);
        if (!finished && d.final_char) end_stream();
      end
      if (due_results.size() > first) begin
        r = due_results[due_results.size() - 1];
        r.last = 1'b1;
        due_results[due_results.size() - 1] = r;
      end
      return live;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_result_beat(ptad_out_t got);
      ptad_out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected beat: byte %02h has %0b end %0b last %0b",
                         got.out_byte, got.has_byte, got.stream_end, got.last));
        return;
      end
      want = due_results.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.has_byte !== want.has_byte)
        report($sformatf("has_byte %0b, want %0b", got.has_byte, want.has_byte));
      if (got.stream_end !== want.stream_end)
        report($sformatf("stream_end %0b, want %0b", got.stream_end, want.stream_end));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ptad_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ptad_out_t out_data;

  decode_scoreboard sb = new();

  int hold_reqs  = 0;
  int holds_done = 0;
  int stall_left = 0;
  int open_left  = 0;
  int quiet_left = 0;
  int live_items = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  predictive_text_armored_decompressor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Result side: check each accepted beat, then pick the stall for the next cycle
  always @(posedge clk) begin : rx_side
    int r;
    if (rst_n && out_valid && !out_stall) sb.check_result_beat(out_data);
    if (holds_done != hold_reqs) begin
      holds_done = hold_reqs;
      stall_left = HOLD_CYCLES;
    end
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (open_left > 0) begin
      open_left--;
      out_stall <= 1'b0;
    end else if (r < 55) begin
      out_stall <= 1'b0;
    end else if (r < 85) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else if (r < 95) begin
      stall_left = $urandom_range(3, 11);
      out_stall <= 1'b1;
    end else if (r < 98) begin
      stall_left = $urandom_range(19, 39);
      out_stall <= 1'b1;
    end else begin
      open_left = $urandom_range(20, 80);
      out_stall <= 1'b0;
    end
  end

  // Mostly short gaps, some long ones, and stretches without any
  function int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    if (r < 98) return $urandom_range(9, 30);
    quiet_left = $urandom_range(10, 40);
    return 0;
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send(ptad_in_t d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (sb.note_char_beat(d)) live_items++;
  endtask

  task automatic send_char(logic [7:0] c, logic fin);
    ptad_in_t d;
    d.action     = ACT_CHAR;
    d.char_code  = c;
    d.final_char = fin;
    send(d);
  endtask

  // Start ignores the other fields, so fill them at random
  task automatic send_start();
    ptad_in_t d;
    d.action     = ACT_START;
    d.char_code  = 8'($urandom_range(0, 255));
    d.final_char = 1'($urandom_range(0, 1));
    send(d);
  endtask

  // Stop offering until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Printable character that is neither quote, backslash nor digit
  function logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == CHAR_QUOTE || c == CHAR_BSLASH || (c >= CHAR_ZERO && c <= CHAR_NINE));
    return c;
  endfunction

  task automatic random_escape(logic fin);
    int r;
    r = $urandom_range(0, 99);
    send_char(CHAR_BSLASH, 1'b0);
    if (r < 15) begin
      send_char(CHAR_N, fin);
    end else if (r < 25) begin
      send_char(CHAR_PLUS, fin);
    end else if (r < 50) begin
      send_char(8'($urandom_range(32, 126)), fin);
    end else begin
      send_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      send_char((r < 90) ? CHAR_ZERO + 8'($urandom_range(0, 7))
                         : 8'($urandom_range(32, 126)), 1'b0);
      send_char((r < 95) ? CHAR_ZERO + 8'($urandom_range(0, 7))
                         : 8'($urandom_range(32, 126)), fin);
    end
  endtask

  // One well-formed stream with random content; squeeze holds the receiver off meanwhile
  task automatic random_stream(bit squeeze);
    int len;
    int kind;
    send_start();
    len = ($urandom_range(0, 9) == 0 || squeeze) ? $urandom_range(30, 60)
                                                 : $urandom_range(3, 20);
    if (squeeze) begin
      hold_reqs++;
      quiet_left = 80;
    end
    for (int k = 0; k < len && !sb.finished; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_char(plain_char(), 1'b0);
      end else if (kind < 70) begin
        // values near the bias give mostly zero bits, so predictions dominate
        send_char(8'($urandom_range(58, 65)), 1'b0);
      end else if (kind < 80) begin
        random_escape(1'b0);
      end else if (kind < 84) begin
        send_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end else if (kind < 93) begin
        send_char($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                       : 8'($urandom_range(127, 255)), 1'b0);
      end else begin
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 19) == 0));
      end
    end
    // Close the stream by quote or by the final mark
    if (!sb.finished) begin
      if ($urandom_range(0, 1)) send_char(CHAR_QUOTE, 1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 3) == 0) random_escape(1'b1);
      else send_char(8'($urandom_range(0, 255)), 1'b1);
    end
    // A few beats past the end, which must give nothing
    repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int streams;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: literal start, zero bits, printable extremes
    send_char(8'h41, 1'b0);
    send_char(8'h3a, 1'b0);
    send_char(CHAR_HI, 1'b0);
    send_char(CHAR_LO, 1'b0);
    // Dropped codes
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CHAR_LF, 1'b0);
    // Newline escape, continuation, escaped quote
    send_char(CHAR_BSLASH, 1'b0);
    send_char(CHAR_N, 1'b0);
    send_char(CHAR_BSLASH, 1'b0);
    send_char(CHAR_PLUS, 1'b0);
    send_char(CHAR_BSLASH, 1'b0);
    send_char(CHAR_QUOTE, 1'b0);
    // Digit escape worth a carriage return, which turns into a line feed
    send_char(CHAR_BSLASH, 1'b0);
    send_char(CHAR_ZERO, 1'b0);
    send_char(CHAR_ZERO + 8'd1, 1'b0);
    send_char(CHAR_ZERO + 8'd5, 1'b0);
    // Digit escape with non-digit tail characters
    send_char(CHAR_BSLASH, 1'b0);
    send_char(CHAR_NINE, 1'b0);
    send_char(CHAR_LO, 1'b0);
    send_char(CHAR_HI, 1'b0);
    // Bit limit ends the stream mid-character; the next beat is ignored
    send_char(CHAR_ZERO + 8'd3, 1'b0);
    send_char(8'h7a, 1'b0);
    send_char(8'h42, 1'b0);
    // Final mark inside an escape, then a plain closing quote
    send_start();
    send_char(CHAR_BSLASH, 1'b1);
    send_start();
    send_char(CHAR_QUOTE, 1'b0);
    drain();

    // Random streams
    live_items = 0;
    streams    = 0;
    while (live_items < RANDOM_ITEMS && streams < MAX_STREAMS) begin
      random_stream(streams == 2);
      streams++;
      if (streams % 7 == 0) drain();
    end

    drain();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("predictive_text_armored_decompressor regression: pass");
    end else begin
      $display("predictive_text_armored_decompressor regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("predictive_text_armored_decompressor regression: fail");
    $finish;
  end

endmodule

[files.f]
src/ptad_pkg.sv
src/ptad_ram.sv
src/ptad_outq.sv
src/predictive_text_armored_decompressor.sv
test/predictive_text_armored_decompressor_test.sv
